### hw/rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and constants of the work slot scheduler: request and status
// codes, sequencer states, table command groups and field widths.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int unsigned WORK_SLOTS_DEF    = 16;
  localparam int unsigned PROGRAM_SLOTS_DEF = 8;

  // Fixed widths of the transaction fields.
  localparam int unsigned ACTION_W       = 2;
  localparam int unsigned TAG_W          = 32;
  localparam int unsigned STREAM_W       = 3;
  localparam int unsigned FINISH_SLOT_W  = 4;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned WORK_SLOT_W    = 4;
  localparam int unsigned PROGRAM_SLOT_W = 3;
  localparam int unsigned AGE_W          = 64;

  // Program reference counts saturate at their all-ones value.
  localparam int unsigned         REFS_W   = 5;
  localparam logic [REFS_W-1:0]   REFS_MAX = '1;

  // Stream code that matches any requester.
  localparam logic [STREAM_W-1:0] ANY_STREAM = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_STOP   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK           = 3'd0,
    STS_NO_ROOM      = 3'd1,
    STS_NONE_PENDING = 3'd2,
    STS_STOPPED      = 3'd3,
    STS_NOT_IN_USE   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PSCAN,
    S_PUPD,
    S_OSCAN,
    S_OUPD,
    S_FRD,
    S_FWAIT,
    S_FUPD,
    S_RESP
  } fsm_e;

  // Work table operations. Reads use the read address, all others the
  // write address.
  typedef struct packed {
    logic rd;
    logic fill;
    logic activate;
    logic release_slot;
  } work_cmd_t;

  // Program table operations. A write also marks the entry valid.
  typedef struct packed {
    logic rd;
    logic wr;
  } prog_cmd_t;

endpackage

### hw/rtl/work_slot_scheduler_core.sv
// ----------------------------------------------------------------------------
// work_slot_scheduler_core
// Slot-based work scheduler with a reference-counted program cache. A
// sequencer walks the work and program tables held in synchronous memories.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_ready_o  action, prog_ident, stream,
//                                                finish_slot
//   out      source     out_valid_o / out_ready_i status, work_slot,
//                                                program_slot, program_reload,
//                                                work_age, work_stream
//
// One transaction is worked at a time. A push scans the work and program
// tables and a pop the work table, one entry per cycle through the table
// read ports; a finish reads the slot and, if it is in use, its program
// entry; a stop or a pop after stop goes straight to the response. The result
// waits in an output register, and the next request is taken while it waits.
// Reset clears all flags and needs no clearing pass.
// ----------------------------------------------------------------------------
module work_slot_scheduler_core #(
  parameter int unsigned WORK_SLOTS    = wss_pkg::WORK_SLOTS_DEF,
  parameter int unsigned PROGRAM_SLOTS = wss_pkg::PROGRAM_SLOTS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [wss_pkg::ACTION_W-1:0]              action_i,
  input  logic [wss_pkg::TAG_W-1:0]                 prog_ident_i,
  input  logic signed [wss_pkg::STREAM_W-1:0]       stream_i,
  input  logic [wss_pkg::FINISH_SLOT_W-1:0]         finish_slot_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [wss_pkg::STATUS_W-1:0]              status_o,
  output logic [wss_pkg::WORK_SLOT_W-1:0]           work_slot_o,
  output logic [wss_pkg::PROGRAM_SLOT_W-1:0]        program_slot_o,
  output logic                                      program_reload_o,
  output logic [wss_pkg::AGE_W-1:0]                 work_age_o,
  output logic signed [wss_pkg::STREAM_W-1:0]       work_stream_o
);

  localparam int unsigned WIW      = (WORK_SLOTS > 1) ? $clog2(WORK_SLOTS) : 1;
  localparam int unsigned PIW      = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1;
  localparam int unsigned SCAN_MAX = (WORK_SLOTS > PROGRAM_SLOTS) ? WORK_SLOTS
                                                                  : PROGRAM_SLOTS;
  localparam int unsigned SIW      = (SCAN_MAX > 1) ? $clog2(SCAN_MAX) : 1;
  localparam int unsigned CW       = $clog2(SCAN_MAX + 1);
  localparam int unsigned WSW      = wss_pkg::WORK_SLOT_W;
  localparam int unsigned PSW      = wss_pkg::PROGRAM_SLOT_W;
  localparam int unsigned RW       = wss_pkg::REFS_W;

  wss_pkg::fsm_e      state_q, state_d;
  wss_pkg::work_cmd_t work_cmd;
  wss_pkg::prog_cmd_t prog_cmd;

  // Table ports.
  logic [WIW-1:0]                 work_rd_addr, work_wr_addr;
  logic [wss_pkg::STREAM_W-1:0]   work_rd_stream;
  logic [PIW-1:0]                 work_rd_prog;
  logic [wss_pkg::AGE_W-1:0]      work_rd_age;
  logic                           work_rd_busy, work_rd_active;
  logic [PIW-1:0]                 prog_rd_addr, prog_wr_addr;
  logic [wss_pkg::TAG_W-1:0]      prog_wr_tag, prog_rd_tag;
  logic [RW-1:0]                  prog_wr_refs, prog_rd_refs;
  logic                           prog_rd_valid;

  // Request and scan state.
  logic [CW-1:0]                  cnt_q;
  logic [SIW-1:0]                 ev_idx_q;
  logic [wss_pkg::TAG_W-1:0]      pid_q;
  logic [wss_pkg::STREAM_W-1:0]   strm_q;
  logic [WIW-1:0]                 fslot_q;
  logic                           pfound_q, pfree_seen_q, wfound_q;
  logic [PIW-1:0]                 pidx_q, pfree_q, fprog_q, sel_prog_q;
  logic [RW-1:0]                  prefs_q;
  logic [WIW-1:0]                 widx_q;
  logic [wss_pkg::AGE_W-1:0]      sel_age_q;
  logic [wss_pkg::STREAM_W-1:0]   sel_strm_q;

  // Result being built, and the output register.
  wss_pkg::status_e               res_status_q, out_status_q;
  logic [WSW-1:0]                 res_work_q, out_work_q;
  logic [PSW-1:0]                 res_prog_q, out_prog_q;
  logic                           res_reload_q, out_reload_q;
  logic [wss_pkg::AGE_W-1:0]      res_age_q, out_age_q;
  logic [wss_pkg::STREAM_W-1:0]   res_strm_q, out_strm_q;
  logic                           out_valid_q;

  logic [wss_pkg::AGE_W-1:0]      next_age_q;
  logic                           running_q;

  logic           out_free, fin_in_range, ev_vld, ev_in_w, ev_in_p;
  logic           prog_match, pop_elig, push_ok;
  logic [PIW-1:0] push_prog;
  logic [RW-1:0]  push_refs, fin_refs;

  wss_work_tbl #(
    .WORK_SLOTS   (WORK_SLOTS),
    .PROGRAM_SLOTS(PROGRAM_SLOTS)
  ) u_work_tbl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (work_cmd),
    .rd_addr_i  (work_rd_addr),
    .wr_addr_i  (work_wr_addr),
    .wr_stream_i(strm_q),
    .wr_prog_i  (push_prog),
    .wr_age_i   (next_age_q),
    .rd_stream_o(work_rd_stream),
    .rd_prog_o  (work_rd_prog),
    .rd_age_o   (work_rd_age),
    .rd_busy_o  (work_rd_busy),
    .rd_active_o(work_rd_active)
  );

  wss_prog_tbl #(
    .PROGRAM_SLOTS(PROGRAM_SLOTS)
  ) u_prog_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (prog_cmd),
    .rd_addr_i (prog_rd_addr),
    .wr_addr_i (prog_wr_addr),
    .wr_tag_i  (prog_wr_tag),
    .wr_refs_i (prog_wr_refs),
    .rd_tag_o  (prog_rd_tag),
    .rd_refs_o (prog_rd_refs),
    .rd_valid_o(prog_rd_valid)
  );

  assign out_free     = !out_valid_q || out_ready_i;
  assign fin_in_range = 32'(finish_slot_i) < WORK_SLOTS;

  // Read data of the previous scan cycle belongs to entry ev_idx_q.
  assign ev_vld     = (cnt_q != '0);
  assign ev_in_w    = ev_vld && (32'(ev_idx_q) < WORK_SLOTS);
  assign ev_in_p    = ev_vld && (32'(ev_idx_q) < PROGRAM_SLOTS);
  assign prog_match = prog_rd_valid && (prog_rd_tag == pid_q);
  assign pop_elig   = work_rd_busy && !work_rd_active &&
                      ((work_rd_stream == strm_q) ||
                       (work_rd_stream == wss_pkg::ANY_STREAM));

  assign push_ok   = (pfound_q || pfree_seen_q) && wfound_q;
  assign push_prog = pfound_q ? pidx_q : pfree_q;
  // A retagged slot had no references, so it starts at one.
  assign push_refs = !pfound_q ? RW'(1) :
                     (prefs_q != wss_pkg::REFS_MAX) ? prefs_q + RW'(1) : prefs_q;
  assign fin_refs  = (prog_rd_refs != '0) ? prog_rd_refs - RW'(1) : prog_rd_refs;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wss_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (wss_pkg::action_e'(action_i))
            wss_pkg::ACT_PUSH:   state_d = wss_pkg::S_PSCAN;
            wss_pkg::ACT_POP:    state_d = running_q ? wss_pkg::S_OSCAN : wss_pkg::S_RESP;
            wss_pkg::ACT_FINISH: state_d = fin_in_range ? wss_pkg::S_FRD : wss_pkg::S_RESP;
            wss_pkg::ACT_STOP:   state_d = wss_pkg::S_RESP;
          endcase
        end
      end
      wss_pkg::S_PSCAN: begin
        if (cnt_q == CW'(SCAN_MAX)) state_d = wss_pkg::S_PUPD;
      end
      wss_pkg::S_PUPD:  state_d = wss_pkg::S_RESP;
      wss_pkg::S_OSCAN: begin
        if (cnt_q == CW'(WORK_SLOTS)) state_d = wss_pkg::S_OUPD;
      end
      wss_pkg::S_OUPD:  state_d = wss_pkg::S_RESP;
      wss_pkg::S_FRD:   state_d = wss_pkg::S_FWAIT;
      wss_pkg::S_FWAIT: state_d = work_rd_busy ? wss_pkg::S_FUPD : wss_pkg::S_RESP;
      wss_pkg::S_FUPD:  state_d = wss_pkg::S_RESP;
      wss_pkg::S_RESP: begin
        if (out_free) state_d = wss_pkg::S_IDLE;
      end
    endcase
  end

  // Table commands. Reads and writes of an entry never overlap because the
  // sequencer finishes its scan before it writes anything back.
  always_comb begin
    work_cmd     = '0;
    prog_cmd     = '0;
    work_rd_addr = cnt_q[WIW-1:0];
    work_wr_addr = widx_q;
    prog_rd_addr = cnt_q[PIW-1:0];
    prog_wr_addr = push_prog;
    prog_wr_tag  = pid_q;
    prog_wr_refs = push_refs;
    in_ready_o   = 1'b0;
    unique case (state_q)
      wss_pkg::S_IDLE: in_ready_o = 1'b1;
      wss_pkg::S_PSCAN: begin
        work_cmd.rd = 32'(cnt_q) < WORK_SLOTS;
        prog_cmd.rd = 32'(cnt_q) < PROGRAM_SLOTS;
      end
      wss_pkg::S_PUPD: begin
        work_cmd.fill = push_ok;
        prog_cmd.wr   = push_ok;
      end
      wss_pkg::S_OSCAN: work_cmd.rd = 32'(cnt_q) < WORK_SLOTS;
      wss_pkg::S_OUPD:  work_cmd.activate = wfound_q;
      wss_pkg::S_FRD: begin
        work_cmd.rd  = 1'b1;
        work_rd_addr = fslot_q;
      end
      wss_pkg::S_FWAIT: begin
        prog_cmd.rd  = work_rd_busy;
        prog_rd_addr = work_rd_prog;
      end
      wss_pkg::S_FUPD: begin
        work_cmd.release_slot = 1'b1;
        work_wr_addr          = fslot_q;
        prog_cmd.wr           = 1'b1;
        prog_wr_addr          = fprog_q;
        prog_wr_tag           = prog_rd_tag;
        prog_wr_refs          = fin_refs;
      end
      wss_pkg::S_RESP: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wss_pkg::S_IDLE;
      running_q   <= 1'b1;
      next_age_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == wss_pkg::S_IDLE && in_valid_i &&
          wss_pkg::action_e'(action_i) == wss_pkg::ACT_STOP) begin
        running_q <= 1'b0;
      end
      if (state_q == wss_pkg::S_PUPD && push_ok) begin
        next_age_q <= next_age_q + 64'd1;
      end
      if (state_q == wss_pkg::S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      wss_pkg::S_IDLE: begin
        if (in_valid_i) begin
          pid_q        <= prog_ident_i;
          strm_q       <= stream_i;
          fslot_q      <= WIW'(finish_slot_i);
          cnt_q        <= '0;
          pfound_q     <= 1'b0;
          pfree_seen_q <= 1'b0;
          wfound_q     <= 1'b0;
          res_work_q   <= '0;
          res_prog_q   <= '0;
          res_reload_q <= 1'b0;
          res_age_q    <= '0;
          res_strm_q   <= '0;
          if (wss_pkg::action_e'(action_i) == wss_pkg::ACT_POP && !running_q) begin
            res_status_q <= wss_pkg::STS_STOPPED;
          end else if (wss_pkg::action_e'(action_i) == wss_pkg::ACT_FINISH &&
                       !fin_in_range) begin
            res_status_q <= wss_pkg::STS_NOT_IN_USE;
          end else begin
            res_status_q <= wss_pkg::STS_OK;
          end
        end
      end
      wss_pkg::S_PSCAN: begin
        cnt_q    <= cnt_q + CW'(1);
        ev_idx_q <= cnt_q[SIW-1:0];
        // The first matching tag wins; free slots count only before it.
        if (ev_in_p && !pfound_q) begin
          if (prog_match) begin
            pfound_q <= 1'b1;
            pidx_q   <= ev_idx_q[PIW-1:0];
            prefs_q  <= prog_rd_refs;
          end else if (prog_rd_refs == '0) begin
            pfree_seen_q <= 1'b1;
            pfree_q      <= ev_idx_q[PIW-1:0];
          end
        end
        if (ev_in_w && !wfound_q && !work_rd_busy) begin
          wfound_q <= 1'b1;
          widx_q   <= ev_idx_q[WIW-1:0];
        end
      end
      wss_pkg::S_PUPD: begin
        if (push_ok) begin
          res_work_q   <= WSW'(widx_q);
          res_prog_q   <= PSW'(push_prog);
          res_reload_q <= !pfound_q;
          res_age_q    <= next_age_q;
        end else begin
          res_status_q <= wss_pkg::STS_NO_ROOM;
        end
      end
      wss_pkg::S_OSCAN: begin
        cnt_q    <= cnt_q + CW'(1);
        ev_idx_q <= cnt_q[SIW-1:0];
        if (ev_in_w && pop_elig && (!wfound_q || work_rd_age < sel_age_q)) begin
          wfound_q   <= 1'b1;
          widx_q     <= ev_idx_q[WIW-1:0];
          sel_age_q  <= work_rd_age;
          sel_prog_q <= work_rd_prog;
          sel_strm_q <= work_rd_stream;
        end
      end
      wss_pkg::S_OUPD: begin
        if (wfound_q) begin
          res_work_q <= WSW'(widx_q);
          res_prog_q <= PSW'(sel_prog_q);
          res_age_q  <= sel_age_q;
          res_strm_q <= sel_strm_q;
        end else begin
          res_status_q <= wss_pkg::STS_NONE_PENDING;
        end
      end
      wss_pkg::S_FRD: ;
      wss_pkg::S_FWAIT: begin
        if (work_rd_busy) begin
          fprog_q <= work_rd_prog;
        end else begin
          res_status_q <= wss_pkg::STS_NOT_IN_USE;
        end
      end
      wss_pkg::S_FUPD: begin
        res_work_q <= WSW'(fslot_q);
        res_prog_q <= PSW'(fprog_q);
      end
      wss_pkg::S_RESP: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_work_q   <= res_work_q;
          out_prog_q   <= res_prog_q;
          out_reload_q <= res_reload_q;
          out_age_q    <= res_age_q;
          out_strm_q   <= res_strm_q;
        end
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign work_slot_o      = out_work_q;
  assign program_slot_o   = out_prog_q;
  assign program_reload_o = out_reload_q;
  assign work_age_o       = out_age_q;
  assign work_stream_o    = $signed(out_strm_q);

  // Every accepted transaction leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != wss_pkg::S_IDLE))
    else $error("accepted transaction did not start work");

  // The age counter only moves on a committed push.
  a_age_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_age_q != $past(next_age_q)) |-> ($past(state_q) == wss_pkg::S_PUPD))
    else $error("age counter moved outside a push");

  // Once stopped, the scheduler stays stopped.
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |=> !running_q)
    else $error("stopped flag cleared");

  // A result appears only when the response step hands it over.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == wss_pkg::S_RESP))
    else $error("result valid without a response step");

endmodule

### hw/rtl/wss_work_tbl.sv
// ----------------------------------------------------------------------------
// wss_work_tbl
// Work slot table: stream, program slot and age per slot in a synchronous
// memory, with in-use and active flags in flops read alongside.
// ----------------------------------------------------------------------------
module wss_work_tbl #(
  parameter int unsigned WORK_SLOTS    = wss_pkg::WORK_SLOTS_DEF,
  parameter int unsigned PROGRAM_SLOTS = wss_pkg::PROGRAM_SLOTS_DEF,
  localparam int unsigned WIW = (WORK_SLOTS > 1) ? $clog2(WORK_SLOTS) : 1,
  localparam int unsigned PIW = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wss_pkg::work_cmd_t            cmd_i,
  input  logic [WIW-1:0]                rd_addr_i,
  input  logic [WIW-1:0]                wr_addr_i,
  input  logic [wss_pkg::STREAM_W-1:0]  wr_stream_i,
  input  logic [PIW-1:0]                wr_prog_i,
  input  logic [wss_pkg::AGE_W-1:0]     wr_age_i,
  output logic [wss_pkg::STREAM_W-1:0]  rd_stream_o,
  output logic [PIW-1:0]                rd_prog_o,
  output logic [wss_pkg::AGE_W-1:0]     rd_age_o,
  output logic                          rd_busy_o,
  output logic                          rd_active_o
);

  localparam int unsigned EW = wss_pkg::STREAM_W + PIW + wss_pkg::AGE_W;

  logic [EW-1:0]         mem_q [WORK_SLOTS];
  logic [EW-1:0]         rd_data_q;
  logic [WORK_SLOTS-1:0] busy_q;
  logic [WORK_SLOTS-1:0] active_q;
  logic                  rd_busy_q;
  logic                  rd_active_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      mem_q[wr_addr_i] <= {wr_stream_i, wr_prog_i, wr_age_i};
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      active_q    <= '0;
      rd_busy_q   <= 1'b0;
      rd_active_q <= 1'b0;
    end else begin
      if (cmd_i.fill) begin
        busy_q[wr_addr_i]   <= 1'b1;
        active_q[wr_addr_i] <= 1'b0;
      end
      if (cmd_i.activate) begin
        active_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.release_slot) begin
        busy_q[wr_addr_i]   <= 1'b0;
        active_q[wr_addr_i] <= 1'b0;
      end
      if (cmd_i.rd) begin
        rd_busy_q   <= busy_q[rd_addr_i];
        rd_active_q <= active_q[rd_addr_i];
      end
    end
  end

  assign rd_stream_o = rd_data_q[EW-1 -: wss_pkg::STREAM_W];
  assign rd_prog_o   = rd_data_q[wss_pkg::AGE_W +: PIW];
  assign rd_age_o    = rd_data_q[wss_pkg::AGE_W-1:0];
  assign rd_busy_o   = rd_busy_q;
  assign rd_active_o = rd_active_q;

endmodule

### hw/rtl/wss_prog_tbl.sv
// ----------------------------------------------------------------------------
// wss_prog_tbl
// Program slot table: tag and reference count per slot in a synchronous
// memory, with valid flags in flops. An invalid slot reads zero references.
// ----------------------------------------------------------------------------
module wss_prog_tbl #(
  parameter int unsigned PROGRAM_SLOTS = wss_pkg::PROGRAM_SLOTS_DEF,
  localparam int unsigned PIW = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wss_pkg::prog_cmd_t          cmd_i,
  input  logic [PIW-1:0]              rd_addr_i,
  input  logic [PIW-1:0]              wr_addr_i,
  input  logic [wss_pkg::TAG_W-1:0]   wr_tag_i,
  input  logic [wss_pkg::REFS_W-1:0]  wr_refs_i,
  output logic [wss_pkg::TAG_W-1:0]   rd_tag_o,
  output logic [wss_pkg::REFS_W-1:0]  rd_refs_o,
  output logic                        rd_valid_o
);

  localparam int unsigned EW = wss_pkg::TAG_W + wss_pkg::REFS_W;

  logic [EW-1:0]            mem_q [PROGRAM_SLOTS];
  logic [EW-1:0]            rd_data_q;
  logic [PROGRAM_SLOTS-1:0] valid_q;
  logic                     rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[wr_addr_i] <= {wr_tag_i, wr_refs_i};
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Counts read as zero after reset; a slot becomes valid when it is first written.
  assign rd_tag_o   = rd_data_q[EW-1 -: wss_pkg::TAG_W];
  assign rd_refs_o  = rd_valid_q ? rd_data_q[wss_pkg::REFS_W-1:0] : '0;
  assign rd_valid_o = rd_valid_q;

endmodule
